/* src/arpr_pkg.sv */
// Package: shared types, constants and reply byte selection for the ARP responder.
`default_nettype none
package arpr_pkg;

   localparam int unsigned BODY_LEN  = 28;
   localparam int unsigned REPLY_LEN = 42;
   localparam int unsigned Q_DEPTH   = 2;

   localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
   localparam logic [15:0] PROTO_IPV4    = 16'h0800;
   localparam logic [15:0] HW_ETHERNET   = 16'h0001;
   localparam logic [15:0] HW_IEEE802    = 16'h0006;
   localparam logic [7:0]  HW_LEN        = 8'd6;
   localparam logic [7:0]  PROTO_LEN     = 8'd4;
   localparam logic [15:0] OP_REQUEST    = 16'h0001;
   localparam logic [15:0] OP_REPLY      = 16'h0002;

   localparam int unsigned POS_W = $clog2(BODY_LEN + 1);
   localparam int unsigned CNT_W = $clog2(REPLY_LEN);
   localparam int unsigned QP_W  = $clog2(Q_DEPTH);
   localparam int unsigned QC_W  = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      CSR_OUR_MAC  = 1'b0,
      CSR_OUR_IPV4 = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [47:0] requester_mac;
      logic [31:0] requester_ip;
      logic        hw_ieee802;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] reply_byte(
      input logic [CNT_W-1:0] cnt,
      input desc_type         d,
      input logic [47:0]      our_mac,
      input logic [31:0]      our_ipv4
   );
      logic [REPLY_LEN*8-1:0] frame;
      logic [CNT_W-1:0]       idx;
      frame = {d.requester_mac, our_mac, ETHERTYPE_ARP,
               (d.hw_ieee802 ? HW_IEEE802 : HW_ETHERNET), PROTO_IPV4,
               HW_LEN, PROTO_LEN, OP_REPLY, our_mac, our_ipv4,
               d.requester_mac, d.requester_ip};
      idx = CNT_W'(REPLY_LEN - 1) - cnt;
      return frame[{idx, 3'b000} +: 8];
   endfunction

endpackage
`default_nettype wire

/* src/arpr_front.sv */
// Front end: captures the ARP body and queues a reply descriptor for valid requests.
`default_nettype none
module arpr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        rx_byte,
   input  wire logic              rx_last,
   input  wire logic [31:0]       our_ipv4,
   input  wire arpr_pkg::q_status_type q_status,
   output logic                   push,
   output arpr_pkg::desc_type     push_desc
);

   logic [arpr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0] hw_kind_ff, hw_kind_in;
   logic [15:0] proto_kind_ff, proto_kind_in;
   logic [7:0]  hw_len_ff, hw_len_in;
   logic [7:0]  proto_len_ff, proto_len_in;
   logic [15:0] op_ff, op_in;
   logic [47:0] req_mac_ff, req_mac_in;
   logic [31:0] req_ip_ff, req_ip_in;
   logic [31:0] tgt_ip_ff, tgt_ip_in;
   logic        accept;
   logic        capture;
   logic        ok;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign capture   = accept && (pos_ff < arpr_pkg::POS_W'(arpr_pkg::BODY_LEN));

   always_comb begin
      hw_kind_in    = hw_kind_ff;
      proto_kind_in = proto_kind_ff;
      hw_len_in     = hw_len_ff;
      proto_len_in  = proto_len_ff;
      op_in         = op_ff;
      req_mac_in    = req_mac_ff;
      req_ip_in     = req_ip_ff;
      tgt_ip_in     = tgt_ip_ff;
      if (capture) begin
         priority if (pos_ff < 5'd2) begin
            hw_kind_in = {hw_kind_ff[7:0], rx_byte};
         end else if (pos_ff < 5'd4) begin
            proto_kind_in = {proto_kind_ff[7:0], rx_byte};
         end else if (pos_ff == 5'd4) begin
            hw_len_in = rx_byte;
         end else if (pos_ff == 5'd5) begin
            proto_len_in = rx_byte;
         end else if (pos_ff < 5'd8) begin
            op_in = {op_ff[7:0], rx_byte};
         end else if (pos_ff < 5'd14) begin
            req_mac_in = {req_mac_ff[39:0], rx_byte};
         end else if (pos_ff < 5'd18) begin
            req_ip_in = {req_ip_ff[23:0], rx_byte};
         end else if (pos_ff < 5'd24) begin
            tgt_ip_in = tgt_ip_ff;
         end else begin
            tgt_ip_in = {tgt_ip_ff[23:0], rx_byte};
         end
      end

      pos_in = pos_ff;
      if (accept) begin
         if (rx_last) begin
            pos_in = '0;
         end else if (capture) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      // body complete once this word lands as the 28th or later
      ok = (pos_ff >= arpr_pkg::POS_W'(arpr_pkg::BODY_LEN - 1))
           && (hw_kind_in == arpr_pkg::HW_ETHERNET || hw_kind_in == arpr_pkg::HW_IEEE802)
           && (proto_kind_in == arpr_pkg::PROTO_IPV4)
           && (hw_len_in == arpr_pkg::HW_LEN)
           && (proto_len_in == arpr_pkg::PROTO_LEN)
           && (op_in == arpr_pkg::OP_REQUEST)
           && (tgt_ip_in == our_ipv4);

      push                    = accept && rx_last && ok;
      push_desc.requester_mac = req_mac_in;
      push_desc.requester_ip  = req_ip_in;
      push_desc.hw_ieee802    = (hw_kind_in == arpr_pkg::HW_IEEE802);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      hw_kind_ff    <= hw_kind_in;
      proto_kind_ff <= proto_kind_in;
      hw_len_ff     <= hw_len_in;
      proto_len_ff  <= proto_len_in;
      op_ff         <= op_in;
      req_mac_ff    <= req_mac_in;
      req_ip_ff     <= req_ip_in;
      tgt_ip_ff     <= tgt_ip_in;
   end

endmodule
`default_nettype wire

/* src/arpr_queue.sv */
// Reply descriptor queue between the front end and the frame emitter.
`default_nettype none
module arpr_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire arpr_pkg::desc_type push_desc,
   input  wire logic               pop,
   output arpr_pkg::desc_type      pop_desc,
   output arpr_pkg::q_status_type  status
);

   arpr_pkg::desc_type entry_ff [arpr_pkg::Q_DEPTH];
   logic [arpr_pkg::QP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [arpr_pkg::QP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [arpr_pkg::QC_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign status.full  = (count_ff == arpr_pkg::QC_W'(arpr_pkg::Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_desc     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

/* src/arpr_back.sv */
// Back end: turns queued descriptors into 42-word Ethernet ARP reply frames.
`default_nettype none
module arpr_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire arpr_pkg::q_status_type q_status,
   input  wire arpr_pkg::desc_type    pop_desc,
   output logic                       pop,
   input  wire logic [47:0]           our_mac,
   input  wire logic [31:0]           our_ipv4,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 tx_byte,
   output logic                       tx_last
);

   logic                       active_ff, active_in;
   logic [arpr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   arpr_pkg::desc_type         desc_ff, desc_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       adv;
   logic                       at_end;

   assign adv    = !valid_ff || !rsp_stall;
   assign at_end = (cnt_ff == arpr_pkg::CNT_W'(arpr_pkg::REPLY_LEN - 1));

   always_comb begin
      pop       = !q_status.empty && (!active_ff || (adv && at_end));
      active_in = active_ff;
      cnt_in    = cnt_ff;
      desc_in   = desc_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (adv) begin
         valid_in = active_ff;
         if (active_ff) begin
            byte_in   = arpr_pkg::reply_byte(cnt_ff, desc_ff, our_mac, our_ipv4);
            last_in   = at_end;
            cnt_in    = cnt_ff + 1'b1;
            active_in = !at_end;
         end
      end
      if (pop) begin
         desc_in   = pop_desc;
         cnt_in    = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         cnt_ff    <= cnt_in;
      end
      desc_ff <= desc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign tx_byte   = byte_ff;
   assign tx_last   = last_ff;

endmodule
`default_nettype wire

/* src/arp_request_responder_top.sv */
// Top level: ARP request responder for one local Ethernet/IPv4 address.
// Usage:
//   req_ channel: one ARP payload word per cycle (req_rx_byte), req_rx_last on
//   the final word of each received frame. Accepted when req_valid && !req_stall.
//   rsp_ channel: 42-word Ethernet ARP reply, rsp_tx_last on the final word.
//   csr_ port: csr_index 0 writes our MAC (48 bit), 1 writes our IPv4 (low 32).
// Reply timing: the final request word pushes a descriptor; an idle emitter pops it
//   and registers the first reply word; words follow one per cycle unless stalled,
//   and a reply already queued starts on the cycle after the previous final word.
// Throughput: input takes one word per cycle. The front end and the emitter
//   are split by a 2-entry descriptor queue; req_stall rises only while the
//   queue is full, which takes more than two replies pending.
// Reset: synchronous, clears the frame position, queue and output register;
//   the CSRs return to zero.
// Receiver stall: the output word register holds; the emitter and the queue
//   fill behind it, then req_stall backs up the input.
`default_nettype none
module arp_request_responder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_rx_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_tx_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [47:0] csr_wdata
);

   logic [47:0] our_mac_ff, our_mac_in;
   logic [31:0] our_ipv4_ff, our_ipv4_in;

   arpr_pkg::q_status_type q_status;
   arpr_pkg::desc_type     push_desc;
   arpr_pkg::desc_type     pop_desc;
   logic                   push;
   logic                   pop;

   always_comb begin
      our_mac_in  = our_mac_ff;
      our_ipv4_in = our_ipv4_ff;
      if (csr_we) begin
         unique case (arpr_pkg::csr_index_type'(csr_index))
            arpr_pkg::CSR_OUR_MAC:  our_mac_in  = csr_wdata;
            arpr_pkg::CSR_OUR_IPV4: our_ipv4_in = csr_wdata[31:0];
            default:                our_mac_in  = our_mac_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         our_mac_ff  <= '0;
         our_ipv4_ff <= '0;
      end else begin
         our_mac_ff  <= our_mac_in;
         our_ipv4_ff <= our_ipv4_in;
      end
   end

   arpr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rx_byte   (req_rx_byte),
      .rx_last   (req_rx_last),
      .our_ipv4  (our_ipv4_ff),
      .q_status  (q_status),
      .push      (push),
      .push_desc (push_desc)
   );

   arpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .status    (q_status)
   );

   arpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_desc  (pop_desc),
      .pop       (pop),
      .our_mac   (our_mac_ff),
      .our_ipv4  (our_ipv4_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .tx_byte   (rsp_tx_byte),
      .tx_last   (rsp_tx_last)
   );

`ifndef SYNTHESIS
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty together");

   a_no_double_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_last && !rsp_stall |=> !(rsp_valid && rsp_tx_last))
      else $error("two final words in a row");

   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !rsp_tx_last)
      else $error("reply burst starts on a final word");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("descriptor pushed into a full queue");
`endif

endmodule
`default_nettype wire

/* tb/tb_arp_request_responder_top.sv */
// Testbench: ARP request responder, directed and random frames checked by a reply predictor.
module tb_arp_request_responder_top;
   import arpr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_WORDS   = 16;

   localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] IP_ONES  = 32'hFFFF_FFFF;
   localparam logic [47:0] PEER_MAC = 48'h0A1B_2C3D_4E5F;
   localparam logic [31:0] PEER_IP  = 32'h0A00_0002;

   localparam int PHASE_IDLE [4]  = '{0, 81, 0, 18};
   localparam int PHASE_STALL [4] = '{0, 0, 81, 18};

   typedef struct packed {
      logic [15:0] hw;
      logic [15:0] proto;
      logic [7:0]  hlen;
      logic [7:0]  plen;
      logic [15:0] opc;
      logic [47:0] smac;
      logic [31:0] sip;
      logic [47:0] tmac;
      logic [31:0] tip;
   } arp_body_t;

   typedef enum logic {
      ROW_SILENT  = 1'b0,
      ROW_REPLIES = 1'b1
   } row_outcome_t;

   typedef struct packed {
      logic         set_cfg;
      logic [47:0]  cfg_mac;
      logic [31:0]  cfg_ip;
      logic [7:0]   len;
      row_outcome_t outcome;
      arp_body_t    body;
   } frame_row_t;

   typedef struct {
      logic [7:0] tx_byte;
      logic       tx_last;
   } reply_word_t;

   // silent rows expect no reply words; replying rows are filled in by the predictor
   localparam frame_row_t DIR_ROWS [6] = '{
      '{1'b0, 48'h0, 32'h0, 8'd28, ROW_REPLIES,
        '{HW_ETHERNET, PROTO_IPV4, HW_LEN, PROTO_LEN, OP_REQUEST, 48'h0, 32'h0, 48'h0, 32'h0}},
      // short frame
      '{1'b0, 48'h0, 32'h0, 8'd27, ROW_SILENT,
        '{HW_ETHERNET, PROTO_IPV4, HW_LEN, PROTO_LEN, OP_REQUEST, PEER_MAC, PEER_IP, 48'h0,
          32'h0}},
      // position must be back at zero after the short one
      '{1'b0, 48'h0, 32'h0, 8'd28, ROW_REPLIES,
        '{HW_IEEE802, PROTO_IPV4, HW_LEN, PROTO_LEN, OP_REQUEST, MAC_ONES, IP_ONES, MAC_ONES,
          32'h0}},
      // trailing bytes ignored
      '{1'b0, 48'h0, 32'h0, 8'd30, ROW_REPLIES,
        '{HW_ETHERNET, PROTO_IPV4, HW_LEN, PROTO_LEN, OP_REQUEST, PEER_MAC, PEER_IP, 48'h0,
          32'h0}},
      // offered while the reply queue is full
      '{1'b0, 48'h0, 32'h0, 8'd1, ROW_SILENT,
        '{HW_ETHERNET, PROTO_IPV4, HW_LEN, PROTO_LEN, OP_REQUEST, PEER_MAC, PEER_IP, 48'h0,
          32'h0}},
      '{1'b1, MAC_ONES, IP_ONES, 8'd28, ROW_REPLIES,
        '{HW_ETHERNET, PROTO_IPV4, HW_LEN, PROTO_LEN, OP_REQUEST, PEER_MAC, PEER_IP, 48'h0,
          IP_ONES}}
   };

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   logic [7:0]    req_rx_byte = 8'h00;
   logic          req_rx_last = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   logic [7:0]    rsp_tx_byte;
   logic          rsp_tx_last;
   logic          csr_we      = 1'b0;
   csr_index_type csr_index   = CSR_OUR_MAC;
   logic [47:0]   csr_wdata   = 48'h0;

   // predictor state
   logic [4:0]  seen_count = 5'd0;
   arp_body_t   held       = '0;
   logic [47:0] cfg_mac    = 48'h0;
   logic [31:0] cfg_ip     = 32'h0;

   reply_word_t reply_words_q [$];
   int          errors        = 0;
   int          words_sent    = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          hold_left     = 0;

   arp_request_responder_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .req_rx_last (req_rx_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_tx_last (rsp_tx_last),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic predict_arp_word(input logic [7:0] b, input logic l, input bit keep);
      logic [REPLY_LEN*8-1:0] frame;
      bit                     answer;
      if (seen_count < BODY_LEN) begin
         if (seen_count < 2) held.hw = {held.hw[7:0], b};
         else if (seen_count < 4) held.proto = {held.proto[7:0], b};
         else if (seen_count == 4) held.hlen = b;
         else if (seen_count == 5) held.plen = b;
         else if (seen_count < 8) held.opc = {held.opc[7:0], b};
         else if (seen_count < 14) held.smac = {held.smac[39:0], b};
         else if (seen_count < 18) held.sip = {held.sip[23:0], b};
         else if (seen_count >= 24) held.tip = {held.tip[23:0], b};
         seen_count++;
      end
      if (l) begin
         answer = seen_count >= BODY_LEN
                  && (held.hw == HW_ETHERNET || held.hw == HW_IEEE802)
                  && held.proto == PROTO_IPV4 && held.hlen == HW_LEN
                  && held.plen == PROTO_LEN && held.opc == OP_REQUEST
                  && held.tip == cfg_ip;
         seen_count = 5'd0;
         if (answer && keep) begin
            frame = {held.smac, cfg_mac, ETHERTYPE_ARP, held.hw, held.proto, held.hlen,
                     held.plen, OP_REPLY, cfg_mac, held.tip, held.smac, held.sip};
            for (int i = 0; i < REPLY_LEN; i++)
               reply_words_q.push_back('{frame[(REPLY_LEN-1-i)*8 +: 8], i == REPLY_LEN - 1});
         end
      end
   endtask

   task automatic send_word(input logic [7:0] b, input logic l, input bit keep);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      req_rx_last <= l;
      do @(posedge clock); while (req_stall);
      words_sent++;
      predict_arp_word(b, l, keep);
   endtask

   task automatic send_frame(input arp_body_t body, input int len, input bit keep);
      logic [223:0] bits;
      logic [7:0]   b;
      bits = body;
      for (int i = 0; i < len; i++) begin
         if (i < BODY_LEN) b = bits[(BODY_LEN-1-i)*8 +: 8];
         else b = 8'($urandom);
         send_word(b, i == len - 1, keep);
      end
   endtask

   // mostly well-formed requests to us; some with one bad field, some pure noise
   task automatic send_random_frame(input bit clean);
      arp_body_t body;
      int        len;
      body.hw    = $urandom_range(1) ? HW_IEEE802 : HW_ETHERNET;
      body.proto = PROTO_IPV4;
      body.hlen  = HW_LEN;
      body.plen  = PROTO_LEN;
      body.opc   = OP_REQUEST;
      body.smac  = 48'({$urandom, $urandom});
      body.sip   = $urandom;
      body.tmac  = 48'({$urandom, $urandom});
      body.tip   = cfg_ip;
      len = ($urandom_range(4) == 0) ? BODY_LEN + $urandom_range(1, 6) : BODY_LEN;
      if (!clean) begin
         case ($urandom_range(19))
            0: body.hw = 16'($urandom);
            1: body.proto = 16'($urandom);
            2: body.hlen = 8'($urandom);
            3: body.plen = 8'($urandom);
            4: body.opc = 16'($urandom);
            5: body.tip = $urandom;
            6: len = $urandom_range(1, BODY_LEN - 1);
            7: begin
               body = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
               len  = $urandom_range(1, 40);
            end
            default: ;
         endcase
      end
      send_frame(body, len, 1'b1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (reply_words_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [47:0] mac, input logic [31:0] ip);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_OUR_MAC;
      csr_wdata <= mac;
      @(posedge clock);
      csr_index <= CSR_OUR_IPV4;
      csr_wdata <= {16'($urandom), ip};
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_mac = mac;
      cfg_ip  = ip;
   endtask

   task automatic check_reply_word();
      reply_word_t want;
      if (reply_words_q.size() == 0) begin
         $error("unexpected reply word: tx_byte %02h, tx_last %0b", rsp_tx_byte, rsp_tx_last);
         errors++;
      end else begin
         want = reply_words_q.pop_front();
         if (rsp_tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, rsp_tx_byte);
            errors++;
         end
         if (rsp_tx_last !== want.tx_last) begin
            $error("tx_last: expected %0b, got %0b", want.tx_last, rsp_tx_last);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_reply_word();
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // receiver holds off through the first rows, so the reply queue fills
      hold_left <= HOLD_CYCLES;
      for (int r = 0; r < $size(DIR_ROWS); r++) begin
         if (DIR_ROWS[r].set_cfg) write_config(DIR_ROWS[r].cfg_mac, DIR_ROWS[r].cfg_ip);
         send_frame(DIR_ROWS[r].body, DIR_ROWS[r].len, DIR_ROWS[r].outcome == ROW_REPLIES);
      end
      for (int p = 0; p < 4; p++) begin
         write_config(48'({$urandom, $urandom}), $urandom);
         send_idle_pct = PHASE_IDLE[p];
         stall_pct <= PHASE_STALL[p];
         start = words_sent;
         while (words_sent - start < PHASE_WORDS) send_random_frame(1'b0);
      end
      settle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
